FILE: hw/rtl/marker_deframer_xor_descrambler_top_macros.svh
// assertion helpers shared by the deframer rtl
`ifndef MARKER_DEFRAMER_XOR_DESCRAMBLER_TOP_MACROS_SVH
`define MARKER_DEFRAMER_XOR_DESCRAMBLER_TOP_MACROS_SVH

// same-cycle implication
`define MDXD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication checked in the next cycle
`define MDXD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/mdxd_pkg.sv
`default_nettype none

package mdxd_pkg;

   localparam int MARKER_BYTES = 8;
   localparam int MARKER_BITS  = 8 * MARKER_BYTES;
   localparam int FILL_W       = $clog2(MARKER_BYTES + 1);

   localparam int KEY_DEPTH = 256;
   localparam int KEY_IDX_W = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
   localparam int KEY_LEN_W = $clog2(KEY_DEPTH + 1);

   // results one item can cause, and the result queue around it
   localparam int RES_MAX   = 3;
   localparam int RES_IDX_W = $clog2(RES_MAX + 1);
   localparam int RSP_DEPTH = 4;
   localparam int RSP_IDX_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_DATA_W = 64;

   localparam logic CSR_KEY_MARKER   = 1'b0;
   localparam logic CSR_SPLIT_MARKER = 1'b1;

   localparam logic [1:0] KIND_DATA    = 2'd0;
   localparam logic [1:0] KIND_SEG_END = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   localparam logic [1:0] ERR_NONE        = 2'd0;
   localparam logic [1:0] ERR_NO_KEY_MARK = 2'd1;
   localparam logic [1:0] ERR_NO_SPLIT    = 2'd2;
   localparam logic [1:0] ERR_KEY_SIZE    = 2'd3;

   localparam logic [2:0] PH_SEEK_KEY = 3'd0;
   localparam logic [2:0] PH_KEY      = 3'd1;
   localparam logic [2:0] PH_SEG0     = 3'd2;
   localparam logic [2:0] PH_SEG1     = 3'd3;
   localparam logic [2:0] PH_DRAIN    = 3'd4;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic       segment;
      logic [1:0] error_code;
      logic       last_of_run;
   } rsp_item_type;

endpackage

`default_nettype wire

FILE: hw/rtl/marker_deframer_xor_descrambler_top.sv
`default_nettype none
// Marker deframer with XOR descrambler.
// req_ carries one stream byte per item, req_tlast marks the final byte of a stream.
// Bytes are dropped until the key marker, the key is collected until the split
// marker, then segment 0 and segment 1 come out XORed with the repeating key.
// rsp_ returns data bytes, segment ends and errors, kind in rsp_tuser; rsp_tlast
// marks the last result one input byte caused (up to three per byte).
// csr_ writes the key marker (index 0) and split marker (index 1); write only idle.
// Flow: an accepted byte waits in the input register and is processed from there,
// once the queue has room, into a four-entry result queue whose head is offered on
// rsp_. Throughput is one byte per cycle; the input register empties whenever the
// queue holds at most one result, which sets the rate under stall.
// A stalled receiver fills the queue, then the input register holds and
// req_tready drops; nothing is lost. Reset (synchronous, active high) clears the
// markers, the queue and the stream state; the key memory needs no clearing
// since only written entries are ever read.
module marker_deframer_xor_descrambler_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [mdxd_pkg::REQ_DATA_W-1:0] req_tdata,  // [7:0] data_byte
   input  wire logic                            req_tlast,  // end_of_stream
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [7:0] out_byte, [8] segment, [10:9] error_code, rest zero
   output logic [mdxd_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [1:0]                           rsp_tuser,  // [1:0] kind
   output logic                                 rsp_tlast,  // last_of_run
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic                            csr_index,
   input  wire logic [mdxd_pkg::CSR_DATA_W-1:0] csr_data
);
   import mdxd_pkg::*;

   logic [MARKER_BITS-1:0] key_marker_ff, split_marker_ff;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   logic [2:0]             phase_ff, phase_in;
   logic [MARKER_BITS-1:0] window_ff, window_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [KEY_LEN_W-1:0]   key_len_ff, key_len_in;
   logic [KEY_IDX_W-1:0]   key_idx_ff, key_idx_in;

   logic [7:0]           key_mem [KEY_DEPTH];
   logic [7:0]           key_rd_ff;
   logic                 key_we;
   logic [KEY_IDX_W-1:0] key_waddr;
   logic [7:0]           key_wdata;

   rsp_item_type         rsp_fifo_ff [RSP_DEPTH];
   logic [RSP_IDX_W-1:0] head_ff, tail_ff;
   logic [RSP_CNT_W-1:0] count_ff;

   rsp_item_type         res [RES_MAX];
   logic [RES_IDX_W-1:0] res_n;

   logic                   proc, pop;
   logic                   full;
   logic [7:0]             old_byte;
   logic [MARKER_BITS-1:0] win_sh;
   logic [FILL_W-1:0]      fill_sh;
   logic                   win_full_sh;
   logic [KEY_IDX_W-1:0]   key_idx_adv;
   rsp_item_type           head_item;

   assign csr_ready  = 1'b1;
   assign proc       = in_valid_ff && (count_ff <= RSP_CNT_W'(RSP_DEPTH - RES_MAX));
   assign req_tready = !in_valid_ff || proc;
   assign pop        = rsp_tvalid && rsp_tready;

   // window shift shared by the marker-hunting phases
   assign full        = (fill_ff == FILL_W'(MARKER_BYTES));
   assign old_byte    = window_ff[MARKER_BITS-1 -: 8];
   assign win_sh      = MARKER_BITS'({window_ff, in_byte_ff});
   assign fill_sh     = full ? fill_ff : fill_ff + FILL_W'(1);
   assign win_full_sh = (fill_sh == FILL_W'(MARKER_BYTES));
   assign key_idx_adv = ((KEY_LEN_W'(key_idx_ff) + KEY_LEN_W'(1)) >= key_len_ff)
                        ? '0 : key_idx_ff + KEY_IDX_W'(1);

   always_comb begin
      phase_in   = phase_ff;
      window_in  = window_ff;
      fill_in    = fill_ff;
      key_len_in = key_len_ff;
      key_idx_in = key_idx_ff;
      key_we     = 1'b0;
      key_waddr  = key_len_ff[KEY_IDX_W-1:0];
      key_wdata  = old_byte;
      res_n      = '0;
      for (int i = 0; i < RES_MAX; i++) begin
         res[i] = '0;
      end
      if (proc) begin
         case (phase_ff)
            PH_SEEK_KEY: begin
               window_in = win_sh;
               fill_in   = fill_sh;
               if (win_full_sh && win_sh == key_marker_ff) begin
                  phase_in  = PH_KEY;
                  window_in = '0;
                  fill_in   = '0;
               end
            end
            PH_KEY: begin
               window_in = win_sh;
               fill_in   = fill_sh;
               if (full && key_len_ff == KEY_LEN_W'(KEY_DEPTH)) begin
                  res[res_n] = '{KIND_ERROR, 8'd0, 1'b0, ERR_KEY_SIZE, 1'b0};
                  res_n      = res_n + RES_IDX_W'(1);
                  phase_in   = PH_DRAIN;
               end else begin
                  if (full) begin
                     key_we     = 1'b1;
                     key_len_in = key_len_ff + KEY_LEN_W'(1);
                  end
                  if (win_full_sh && win_sh == split_marker_ff) begin
                     window_in  = '0;
                     fill_in    = '0;
                     key_idx_in = '0;
                     if (key_len_in == '0) begin
                        res[res_n] = '{KIND_ERROR, 8'd0, 1'b0, ERR_KEY_SIZE, 1'b0};
                        res_n      = res_n + RES_IDX_W'(1);
                        phase_in   = PH_DRAIN;
                     end else begin
                        phase_in = PH_SEG0;
                     end
                  end
               end
            end
            PH_SEG0: begin
               window_in = win_sh;
               fill_in   = fill_sh;
               if (full) begin
                  res[res_n] = '{KIND_DATA, old_byte ^ key_rd_ff, 1'b0, ERR_NONE, 1'b0};
                  res_n      = res_n + RES_IDX_W'(1);
                  key_idx_in = key_idx_adv;
               end
               if (win_full_sh && win_sh == split_marker_ff) begin
                  res[res_n] = '{KIND_SEG_END, 8'd0, 1'b0, ERR_NONE, 1'b0};
                  res_n      = res_n + RES_IDX_W'(1);
                  window_in  = '0;
                  fill_in    = '0;
                  key_idx_in = '0;
                  phase_in   = PH_SEG1;
               end
            end
            PH_SEG1: begin
               res[res_n] = '{KIND_DATA, in_byte_ff ^ key_rd_ff, 1'b1, ERR_NONE, 1'b0};
               res_n      = res_n + RES_IDX_W'(1);
               key_idx_in = key_idx_adv;
            end
            default: begin
            end
         endcase
         if (in_last_ff) begin
            case (phase_in)
               PH_SEEK_KEY: begin
                  res[res_n] = '{KIND_ERROR, 8'd0, 1'b0, ERR_NO_KEY_MARK, 1'b0};
                  res_n      = res_n + RES_IDX_W'(1);
               end
               PH_KEY, PH_SEG0: begin
                  res[res_n] = '{KIND_ERROR, 8'd0, 1'b0, ERR_NO_SPLIT, 1'b0};
                  res_n      = res_n + RES_IDX_W'(1);
               end
               PH_SEG1: begin
                  res[res_n] = '{KIND_SEG_END, 8'd0, 1'b1, ERR_NONE, 1'b0};
                  res_n      = res_n + RES_IDX_W'(1);
               end
               default: begin
               end
            endcase
            // a new stream starts with the next byte
            phase_in   = PH_SEEK_KEY;
            window_in  = '0;
            fill_in    = '0;
            key_len_in = '0;
            key_idx_in = '0;
         end
         if (res_n != '0) begin
            res[res_n - RES_IDX_W'(1)].last_of_run = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_marker_ff   <= '0;
         split_marker_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_KEY_MARKER:   key_marker_ff   <= csr_data[MARKER_BITS-1:0];
            CSR_SPLIT_MARKER: split_marker_ff <= csr_data[MARKER_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata[7:0];
         in_last_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SEEK_KEY;
         window_ff  <= '0;
         fill_ff    <= '0;
         key_len_ff <= '0;
         key_idx_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         window_ff  <= window_in;
         fill_ff    <= fill_in;
         key_len_ff <= key_len_in;
         key_idx_ff <= key_idx_in;
      end
   end

   // key read runs every cycle so the entry for the next byte is always ready
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_waddr] <= key_wdata;
      end
      key_rd_ff <= key_mem[key_idx_in];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < RES_MAX; i++) begin
         if (RES_IDX_W'(i) < res_n) begin
            rsp_fifo_ff[tail_ff + RSP_IDX_W'(i)] <= res[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         tail_ff  <= tail_ff + RSP_IDX_W'(res_n);
         head_ff  <= head_ff + RSP_IDX_W'(pop);
         count_ff <= count_ff + RSP_CNT_W'(res_n) - RSP_CNT_W'(pop);
      end
   end

   assign head_item  = rsp_fifo_ff[head_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = {5'd0, head_item.error_code, head_item.segment, head_item.out_byte};
   assign rsp_tuser  = head_item.kind;
   assign rsp_tlast  = head_item.last_of_run;

`include "marker_deframer_xor_descrambler_top_macros.svh"

   `MDXD_ASSERT_NOW(a_queue_bound, clock, reset, 1'b1,
      count_ff <= RSP_CNT_W'(RSP_DEPTH), "result queue overflow")
   `MDXD_ASSERT_NOW(a_key_idx_range, clock, reset,
      phase_ff == PH_SEG0 || phase_ff == PH_SEG1,
      KEY_LEN_W'(key_idx_ff) < key_len_ff, "key index beyond key length")
   `MDXD_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1,
      fill_ff <= FILL_W'(MARKER_BYTES), "window fill beyond marker size")
   `MDXD_ASSERT_NEXT(a_eos_restart, clock, reset, proc && in_last_ff,
      phase_ff == PH_SEEK_KEY && key_len_ff == '0, "stream end did not restart")
   `MDXD_ASSERT_NEXT(a_hold_on_stall, clock, reset, in_valid_ff && !proc,
      in_valid_ff, "pending byte dropped while stalled")

endmodule

`default_nettype wire

FILE: sim/deframer_checker.sv
module deframer_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   input  wire logic [mdxd_pkg::REQ_DATA_W-1:0] req_tdata,   // [7:0] data_byte
   input  wire logic                            req_tlast,   // end_of_stream
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [7:0] out_byte, [8] segment, [10:9] error_code
   input  wire logic [mdxd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic [1:0]                      rsp_tuser,   // [1:0] kind
   input  wire logic                            rsp_tlast,   // last_of_run
   input  wire logic                            csr_valid,
   input  wire logic                            csr_ready,
   input  wire logic                            csr_index,
   input  wire logic [mdxd_pkg::CSR_DATA_W-1:0] csr_data,
   output int                                   mismatch_count,
   output int                                   results_awaited
);
   import mdxd_pkg::*;

   // register copies
   logic [CSR_DATA_W-1:0] key_mark;
   logic [CSR_DATA_W-1:0] split_mark;

   // stream state
   logic [2:0]             stream_phase;
   logic [MARKER_BITS-1:0] marker_win;
   int unsigned            win_fill;
   logic [7:0]             key_mem [KEY_DEPTH];
   int unsigned            key_len;
   int unsigned            key_pos;

   rsp_item_type descrambled_q[$];
   rsp_item_type step_q[$];
   int           errors_seen = 0;

   assign mismatch_count = errors_seen;

   task automatic report(input string msg);
      errors_seen++;
      $display("%0t mismatch: %s", $time, msg);
   endtask

   task automatic restart_stream();
      stream_phase = PH_SEEK_KEY;
      marker_win   = '0;
      win_fill     = 0;
      key_len      = 0;
      key_pos      = 0;
   endtask

   task automatic add_result(input logic [1:0] kind, input logic [7:0] value,
                             input logic seg, input logic [1:0] err);
      rsp_item_type r;
      r.kind        = kind;
      r.out_byte    = value;
      r.segment     = seg;
      r.error_code  = err;
      r.last_of_run = 1'b0;
      step_q.push_back(r);
   endtask

   // oldest byte falls out once the window is full
   task automatic shift_window(input logic [7:0] b, output logic spilled,
                               output logic [7:0] oldest);
      spilled = (win_fill >= MARKER_BYTES);
      oldest  = marker_win[MARKER_BITS-1 -: 8];
      if (!spilled)
         win_fill++;
      marker_win = (marker_win << 8) | MARKER_BITS'(b);
   endtask

   function automatic logic window_hit(input logic [CSR_DATA_W-1:0] pattern);
      return (win_fill >= MARKER_BYTES) && (marker_win == pattern[MARKER_BITS-1:0]);
   endfunction

   function automatic logic [7:0] unscramble(input logic [7:0] b);
      logic [7:0] k;
      k = key_mem[key_pos];
      key_pos++;
      if (key_pos >= key_len)
         key_pos = 0;
      return b ^ k;
   endfunction

   task automatic descramble_byte(input logic [7:0] b, input logic eos);
      logic       spilled;
      logic [7:0] oldest;
      step_q.delete();
      case (stream_phase)
         PH_SEEK_KEY: begin
            shift_window(b, spilled, oldest);
            if (window_hit(key_mark)) begin
               stream_phase = PH_KEY;
               marker_win   = '0;
               win_fill     = 0;
            end
         end
         PH_KEY: begin
            shift_window(b, spilled, oldest);
            if (spilled) begin
               if (key_len >= KEY_DEPTH) begin
                  add_result(KIND_ERROR, 8'h00, 1'b0, ERR_KEY_SIZE);
                  stream_phase = PH_DRAIN;
               end else begin
                  key_mem[key_len] = oldest;
                  key_len++;
               end
            end
            // an oversized key skips the marker check on this item
            if (stream_phase == PH_KEY && window_hit(split_mark)) begin
               marker_win = '0;
               win_fill   = 0;
               key_pos    = 0;
               if (key_len == 0) begin
                  add_result(KIND_ERROR, 8'h00, 1'b0, ERR_KEY_SIZE);
                  stream_phase = PH_DRAIN;
               end else begin
                  stream_phase = PH_SEG0;
               end
            end
         end
         PH_SEG0: begin
            shift_window(b, spilled, oldest);
            if (spilled)
               add_result(KIND_DATA, unscramble(oldest), 1'b0, ERR_NONE);
            if (window_hit(split_mark)) begin
               add_result(KIND_SEG_END, 8'h00, 1'b0, ERR_NONE);
               marker_win   = '0;
               win_fill     = 0;
               key_pos      = 0;
               stream_phase = PH_SEG1;
            end
         end
         PH_SEG1: add_result(KIND_DATA, unscramble(b), 1'b1, ERR_NONE);
         default: ;
      endcase
      if (eos) begin
         if (stream_phase == PH_SEEK_KEY)
            add_result(KIND_ERROR, 8'h00, 1'b0, ERR_NO_KEY_MARK);
         else if (stream_phase inside {PH_KEY, PH_SEG0})
            add_result(KIND_ERROR, 8'h00, 1'b0, ERR_NO_SPLIT);
         else if (stream_phase == PH_SEG1)
            add_result(KIND_SEG_END, 8'h00, 1'b1, ERR_NONE);
         restart_stream();
      end
      if (step_q.size() > 0)
         step_q[step_q.size()-1].last_of_run = 1'b1;
      foreach (step_q[i])
         descrambled_q.push_back(step_q[i]);
   endtask

   task automatic check_result();
      rsp_item_type got;
      rsp_item_type want;
      got.kind        = rsp_tuser;
      got.out_byte    = rsp_tdata[7:0];
      got.segment     = rsp_tdata[8];
      got.error_code  = rsp_tdata[10:9];
      got.last_of_run = rsp_tlast;
      if (descrambled_q.size() == 0) begin
         report($sformatf("result with nothing expected: kind %0d byte %02h",
                          got.kind, got.out_byte));
      end else begin
         want = descrambled_q.pop_front();
         if (got.kind !== want.kind)
            report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
         if (got.out_byte !== want.out_byte)
            report($sformatf("out_byte %02h, expected %02h", got.out_byte, want.out_byte));
         if (got.segment !== want.segment)
            report($sformatf("segment %0d, expected %0d", got.segment, want.segment));
         if (got.error_code !== want.error_code)
            report($sformatf("error_code %0d, expected %0d", got.error_code,
                             want.error_code));
         if (got.last_of_run !== want.last_of_run)
            report($sformatf("last_of_run %0d, expected %0d", got.last_of_run,
                             want.last_of_run));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         key_mark   = '0;
         split_mark = '0;
         restart_stream();
         descrambled_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_KEY_MARKER)
               key_mark = csr_data;
            else
               split_mark = csr_data;
         end
         if (req_tvalid && req_tready)
            descramble_byte(req_tdata[7:0], req_tlast);
         if (rsp_tvalid && rsp_tready)
            check_result();
      end
      results_awaited <= descrambled_q.size();
   end

endmodule

FILE: sim/tb_marker_deframer_xor_descrambler_top.sv
module tb_marker_deframer_xor_descrambler_top;
   import mdxd_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 80;
   localparam int PHASE_ITEMS = 80;
   localparam int NUM_PHASES  = 4;

   typedef enum int {
      SK_FULL,
      SK_EMPTY_SEG1,
      SK_NO_SECOND_SPLIT,
      SK_EMPTY_KEY,
      SK_NO_SPLIT,
      SK_NO_KEY_MARK,
      SK_TRUNCATED,
      SK_LONG_KEY,
      SK_KEY_TOO_LONG
   } stream_kind_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // [7:0] data_byte
   logic                  req_tlast;   // end_of_stream
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [7:0] out_byte, [8] segment, [10:9] error_code
   logic [1:0]            rsp_tuser;   // [1:0] kind
   logic                  rsp_tlast;   // last_of_run
   logic                  csr_valid;
   logic                  csr_ready;
   logic                  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   int mismatches;
   int results_awaited;
   bit no_gaps;
   int phase_items;

   logic [CSR_DATA_W-1:0] key_pat;
   logic [CSR_DATA_W-1:0] split_pat;
   logic [7:0]            stream_q[$];

   marker_deframer_xor_descrambler_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   deframer_checker descramble_watch (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatch_count  (mismatches),
      .results_awaited (results_awaited)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: random stalls, one long hold-off once results are flowing
   initial begin
      int seen;
      int hold_left;
      bit held;
      seen      = 0;
      hold_left = 0;
      held      = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            seen++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!held && seen >= 40) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= no_gaps || ($urandom_range(0, 99) >= 30);
         end
      end
   end

   // watchdog on cycles with no handshake anywhere
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("marker_deframer_xor_descrambler_top regression: fail");
      $finish;
   end

   task automatic send_item(input logic [7:0] b, input logic eos);
      if (!no_gaps && $urandom_range(0, 99) < 30) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eos;
      do @(posedge clock); while (!req_tready);
      phase_items++;
   endtask

   task automatic send_stream();
      foreach (stream_q[i])
         send_item(stream_q[i], i == stream_q.size() - 1);
   endtask

   task automatic write_reg(input logic idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (results_awaited != 0)
         @(posedge clock);
   endtask

   // first stream byte is the most significant byte of the pattern
   task automatic add_marker(input logic [CSR_DATA_W-1:0] pattern);
      for (int j = 0; j < MARKER_BYTES; j++)
         stream_q.push_back(pattern[8*(MARKER_BYTES-1-j) +: 8]);
   endtask

   task automatic add_random(input int count);
      repeat (count) stream_q.push_back(8'($urandom));
   endtask

   task automatic build_stream(input stream_kind_type kind);
      int key_n;
      int cut;
      key_n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      stream_q.delete();
      if (kind != SK_NO_KEY_MARK)
         add_random($urandom_range(0, 4));
      case (kind)
         SK_NO_KEY_MARK: add_random($urandom_range(1, 10));
         SK_EMPTY_KEY: begin
            add_marker(key_pat);
            add_marker(split_pat);
            add_random($urandom_range(0, 5));
         end
         SK_NO_SPLIT: begin
            add_marker(key_pat);
            add_random($urandom_range(0, 12));
         end
         SK_KEY_TOO_LONG: begin
            add_marker(key_pat);
            add_random(KEY_DEPTH + MARKER_BYTES + $urandom_range(1, 4));
            add_marker(split_pat);
            add_random($urandom_range(0, 4));
         end
         default: begin
            add_marker(key_pat);
            add_random(kind == SK_LONG_KEY ? KEY_DEPTH : key_n);
            add_marker(split_pat);
            add_random(kind == SK_NO_SECOND_SPLIT ? $urandom_range(1, 12)
                                                  : $urandom_range(0, 12));
            if (kind != SK_NO_SECOND_SPLIT)
               add_marker(split_pat);
            // long key: segment one runs past the key length so the index wraps
            if (kind == SK_LONG_KEY)
               add_random(KEY_DEPTH + 4);
            else if (kind inside {SK_FULL, SK_TRUNCATED})
               add_random($urandom_range(1, 10));
         end
      endcase
      if (kind == SK_TRUNCATED) begin
         cut = $urandom_range(1, stream_q.size());
         while (stream_q.size() > cut)
            void'(stream_q.pop_back());
      end
   endtask

   function automatic stream_kind_type pick_kind();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 38) return SK_FULL;
      if (roll < 46) return SK_EMPTY_SEG1;
      if (roll < 56) return SK_NO_SECOND_SPLIT;
      if (roll < 63) return SK_EMPTY_KEY;
      if (roll < 73) return SK_NO_SPLIT;
      if (roll < 85) return SK_NO_KEY_MARK;
      return SK_TRUNCATED;
   endfunction

   initial begin
      logic [CSR_DATA_W-1:0] key_set   [NUM_PHASES];
      logic [CSR_DATA_W-1:0] split_set [NUM_PHASES];
      int                    n_streams;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = CSR_KEY_MARKER;
      csr_data   = '0;
      no_gaps    = 1'b0;

      key_set[0]   = {$urandom, $urandom};
      split_set[0] = {$urandom, $urandom};
      key_set[1]   = '0;
      split_set[1] = '1;
      key_set[2]   = '1;
      split_set[2] = '0;
      key_set[3]   = {$urandom, $urandom};
      split_set[3] = {$urandom, $urandom};

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p > 0) begin
            wait_drained();
            // bytes with no result may still be in flight
            repeat (6) @(posedge clock);
         end
         key_pat   = key_set[p];
         split_pat = split_set[p];
         write_reg(CSR_KEY_MARKER, key_pat);
         write_reg(CSR_SPLIT_MARKER, split_pat);
         csr_valid <= 1'b0;
         no_gaps     = (p == 1);
         phase_items = 0;
         n_streams   = 0;

         if (p == 0) begin
            // lone end-of-stream bytes, then a key marker straight into a split marker
            send_item(8'h00, 1'b1);
            send_item(8'hFF, 1'b1);
            stream_q.delete();
            add_marker(key_pat);
            add_marker(split_pat);
            send_stream();
         end
         if (p == NUM_PHASES - 1) begin
            build_stream(SK_LONG_KEY);
            send_stream();
            build_stream(SK_KEY_TOO_LONG);
            send_stream();
            phase_items = 0;
         end

         while (phase_items < PHASE_ITEMS) begin
            if (p == 0 && n_streams <= int'(SK_TRUNCATED))
               build_stream(stream_kind_type'(n_streams));
            else
               build_stream(pick_kind());
            send_stream();
            n_streams++;
         end
         req_tvalid <= 1'b0;
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && results_awaited == 0)
         $display("marker_deframer_xor_descrambler_top regression: pass");
      else
         $display("marker_deframer_xor_descrambler_top regression: fail");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/mdxd_pkg.sv
hw/rtl/marker_deframer_xor_descrambler_top.sv
sim/deframer_checker.sv
sim/tb_marker_deframer_xor_descrambler_top.sv
